/* hw/rtl/dsi128_pkg.sv */
// Shared types, character codes and error ranking for the decimal string to int128 unit.
package dsi128_pkg;

   // Most significant digits held in the 128-bit accumulator
   localparam logic [5:0] DIGIT_LIMIT = 6'd38;

   // Exponent magnitude saturates at 2^31
   localparam logic [34:0] EXP_LIMIT = 35'h0_8000_0000;

   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_POINT   = 8'h2E;
   localparam logic [7:0] CHAR_E_UPPER = 8'h45;
   localparam logic [7:0] CHAR_E_LOWER = 8'h65;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   typedef enum logic [1:0] {
      PH_START,
      PH_MANT,
      PH_EXP_START,
      PH_EXP_BODY
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_CHAR,
      ERR_DIGITS,
      ERR_EXP
   } err_type;

   typedef enum logic [1:0] {
      ST_PARSE,
      ST_CHECK,
      ST_APPEND,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic step;      // apply the accepted character
      logic check;     // final checks, load the zero count
      logic append;    // acc = acc * 10, count down
      logic load_out;  // capture the result item
      logic clear;     // back to start of string
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic append_done;
   } status_type;

   // Invalid character above bad exponent above too many digits
   function automatic logic [1:0] err_rank(input err_type e);
      logic [1:0] r;
      case (e)
         ERR_CHAR:   r = 2'd3;
         ERR_EXP:    r = 2'd2;
         ERR_DIGITS: r = 2'd1;
         default:    r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic err_type err_raise(input err_type cur, input err_type nw);
      return (err_rank(nw) > err_rank(cur)) ? nw : cur;
   endfunction

endpackage

/* hw/rtl/dsi128_ctrl.sv */
// Sequencing state machine and handshake control for the decimal string to int128 unit.
module dsi128_ctrl
   import dsi128_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PARSE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_PARSE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.step = 1'b1;
               if (req_tlast) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_APPEND;
         end
         ST_APPEND: begin
            if (status.append_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.append = 1'b1;
            end
         end
         ST_DONE: begin
            // hold until the output slot is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_PARSE;
            end
         end
         default: begin
            state_in = ST_PARSE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* hw/rtl/dsi128_dpath.sv */
// Parse registers, 128-bit accumulator and result register of the decimal string to int128 unit.
module dsi128_dpath
   import dsi128_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  logic [7:0]   char_code,
   output status_type   status,
   output logic [63:0]  value_low_word,
   output logic [63:0]  value_high_word,
   output logic [1:0]   error_code
);

   phase_type    phase_ff, phase_in;
   logic         neg_ff, neg_in;
   logic         point_ff, point_in;
   logic         lead_ff, lead_in;
   logic [5:0]   pending_ff, pending_in;
   logic [5:0]   dcount_ff, dcount_in;
   logic [5:0]   frac_ff, frac_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  emag_ff, emag_in;
   logic         eneg_ff, eneg_in;
   logic         eseen_ff, eseen_in;
   err_type      err_ff, err_in;

   logic [63:0]  out_lo_ff, out_hi_ff;
   logic [1:0]   out_err_ff;

   logic         num_char;
   logic [3:0]   digit_val;
   logic [3:0]   mul_digit;
   logic [127:0] acc_mul;
   logic [127:0] acc_neg;
   logic [127:0] result;
   logic [34:0]  exp_prod;
   logic         mant_char;
   logic [5:0]   size_eff;
   logic [5:0]   frac_eff;
   logic [5:0]   room;
   logic [31:0]  zeros;

   assign num_char  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign digit_val = 4'(char_code - CHAR_ZERO);

   // one shared times-ten unit for digit entry and zero append
   assign mul_digit = cmd.append ? 4'd0 : digit_val;
   assign acc_mul   = (acc_ff << 3) + (acc_ff << 1) + {124'd0, mul_digit};

   assign exp_prod  = ({3'd0, emag_ff} << 3) + ({3'd0, emag_ff} << 1) + {31'd0, digit_val};

   assign mant_char = ((phase_ff == PH_START) && (char_code != CHAR_MINUS))
                      || (phase_ff == PH_MANT);

   // effective size and fraction length; no digits counts as a single 0
   assign size_eff = (dcount_ff == 6'd0) ? 6'd1 : dcount_ff;
   assign frac_eff = !point_ff ? 6'd0 : ((dcount_ff == 6'd0) ? 6'd1 : frac_ff);
   assign room     = DIGIT_LIMIT - size_eff;
   assign zeros    = (!eneg_ff && (emag_ff > {26'd0, frac_eff}))
                     ? (emag_ff - {26'd0, frac_eff}) : 32'd0;

   always_comb begin
      phase_in   = phase_ff;
      neg_in     = neg_ff;
      point_in   = point_ff;
      lead_in    = lead_ff;
      pending_in = pending_ff;
      dcount_in  = dcount_ff;
      frac_in    = frac_ff;
      acc_in     = acc_ff;
      emag_in    = emag_ff;
      eneg_in    = eneg_ff;
      eseen_in   = eseen_ff;
      err_in     = err_ff;

      if (cmd.step) begin
         if (phase_ff == PH_START) begin
            phase_in = PH_MANT;
            if (char_code == CHAR_MINUS) begin
               neg_in = 1'b1;
            end
         end
         if (mant_char) begin
            if (num_char) begin
               if (lead_ff && (char_code == CHAR_ZERO)) begin
                  // skip leading zero, count saturating
                  if (pending_ff != 6'd63) begin
                     pending_in = pending_ff + 6'd1;
                  end
               end else begin
                  lead_in = 1'b0;
                  if (dcount_ff >= DIGIT_LIMIT) begin
                     err_in = err_raise(err_ff, ERR_DIGITS);
                  end else begin
                     acc_in    = acc_mul;
                     dcount_in = dcount_ff + 6'd1;
                     if (point_ff) begin
                        frac_in = frac_ff + 6'd1;
                     end
                  end
               end
            end else if (char_code == CHAR_POINT) begin
               lead_in = 1'b0;
               if (point_ff) begin
                  err_in = err_raise(err_ff, ERR_CHAR);
               end else begin
                  if (dcount_ff >= DIGIT_LIMIT) begin
                     err_in = err_raise(err_ff, ERR_DIGITS);
                  end
                  point_in = 1'b1;
               end
            end else if ((char_code == CHAR_E_UPPER) || (char_code == CHAR_E_LOWER)) begin
               lead_in  = 1'b0;
               phase_in = PH_EXP_START;
            end else begin
               lead_in = 1'b0;
               err_in  = err_raise(err_ff, ERR_CHAR);
            end
         end else if ((phase_ff == PH_EXP_START) || (phase_ff == PH_EXP_BODY)) begin
            if (num_char) begin
               if (exp_prod > EXP_LIMIT) begin
                  err_in  = err_raise(err_ff, ERR_EXP);
                  emag_in = EXP_LIMIT[31:0];
               end else begin
                  emag_in = exp_prod[31:0];
               end
               eseen_in = 1'b1;
               phase_in = PH_EXP_BODY;
            end else if ((phase_ff == PH_EXP_START)
                         && ((char_code == CHAR_PLUS) || (char_code == CHAR_MINUS))) begin
               eneg_in  = (char_code == CHAR_MINUS);
               phase_in = PH_EXP_BODY;
            end else begin
               err_in = err_raise(err_ff, ERR_EXP);
            end
         end
      end

      if (cmd.check) begin
         err_in = err_ff;
         if ((phase_ff == PH_EXP_START) || (phase_ff == PH_EXP_BODY)) begin
            if (!eseen_ff) begin
               err_in = err_raise(err_in, ERR_EXP);
            end else if (!eneg_ff && emag_ff[31]) begin
               err_in = err_raise(err_in, ERR_EXP);
            end
         end
         if (lead_ff && (pending_ff > DIGIT_LIMIT)) begin
            err_in = err_raise(err_in, ERR_DIGITS);
         end
         if (zeros > {26'd0, room}) begin
            err_in = err_raise(err_in, ERR_DIGITS);
         end
         // zero count is only used when it fits
         pending_in = zeros[5:0];
      end

      if (cmd.append) begin
         acc_in     = acc_mul;
         pending_in = pending_ff - 6'd1;
      end

      if (cmd.clear) begin
         phase_in   = PH_START;
         neg_in     = 1'b0;
         point_in   = 1'b0;
         lead_in    = 1'b1;
         pending_in = 6'd0;
         dcount_in  = 6'd0;
         frac_in    = 6'd0;
         acc_in     = '0;
         emag_in    = 32'd0;
         eneg_in    = 1'b0;
         eseen_in   = 1'b0;
         err_in     = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         neg_ff     <= 1'b0;
         point_ff   <= 1'b0;
         lead_ff    <= 1'b1;
         pending_ff <= 6'd0;
         dcount_ff  <= 6'd0;
         frac_ff    <= 6'd0;
         acc_ff     <= '0;
         emag_ff    <= 32'd0;
         eneg_ff    <= 1'b0;
         eseen_ff   <= 1'b0;
         err_ff     <= ERR_NONE;
      end else begin
         phase_ff   <= phase_in;
         neg_ff     <= neg_in;
         point_ff   <= point_in;
         lead_ff    <= lead_in;
         pending_ff <= pending_in;
         dcount_ff  <= dcount_in;
         frac_ff    <= frac_in;
         acc_ff     <= acc_in;
         emag_ff    <= emag_in;
         eneg_ff    <= eneg_in;
         eseen_ff   <= eseen_in;
         err_ff     <= err_in;
      end
   end

   assign status.append_done = (pending_ff == 6'd0) || (err_ff != ERR_NONE);

   // error result carries zero value words
   assign acc_neg = ~acc_ff + 128'd1;
   assign result  = (err_ff != ERR_NONE) ? 128'd0 : (neg_ff ? acc_neg : acc_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_lo_ff  <= result[63:0];
         out_hi_ff  <= result[127:64];
         out_err_ff <= err_ff;
      end
   end

   assign value_low_word  = out_lo_ff;
   assign value_high_word = out_hi_ff;
   assign error_code      = out_err_ff;

endmodule

/* hw/rtl/decimal_string_to_int128_unit.sv */
// Top level of the decimal string to int128 unit: controller and datapath.
//
// Converts an ASCII decimal string, one character item per req_ handshake,
// into a two's complement 128-bit integer. req_tdata carries the character,
// req_tlast marks the final character of the string; only that item yields a
// result item on the rsp_ channel: value in rsp_tdata, error code in rsp_tuser
// (0 ok, 1 invalid character, 2 too many digits, 3 bad exponent). An error
// result carries a zero value.
// Throughput: one character per cycle while a string is being read. After the
// final character the unit runs the end checks, then appends the exponent
// zeros (0 to 37, one times-ten step of the shared 128-bit multiply-add each),
// then loads the output register; the next string may start right after.
// Reset (synchronous, active high) returns the parser to the start of a string
// and drops any pending result item. When the receiver stalls the result item
// holds in the output register while the next string is read; a second result
// waits in the final state until the first is taken.
module decimal_string_to_int128_unit
   import dsi128_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] char_code
   input  logic         req_tlast,   // last_char
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] value_low_word, [127:64] value_high_word
   output logic [1:0]   rsp_tuser    // [1:0] error_code
);

   cmd_type    cmd;
   status_type status;

   // sequencing and handshakes
   dsi128_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // parse state, accumulator and result register
   dsi128_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .char_code       (req_tdata),
      .status          (status),
      .value_low_word  (rsp_tdata[63:0]),
      .value_high_word (rsp_tdata[127:64]),
      .error_code      (rsp_tuser)
   );

endmodule
